### design/cur_pkg.sv
package cur_pkg;

	// Field widths
	localparam int CPU_W   = 3;
	localparam int NUM_CPUS = 1 << CPU_W;
	localparam int TIME_W  = 63;
	localparam int UTIL_W  = 11;
	localparam int SUM_W   = UTIL_W + 2;
	localparam int TICK_W  = 30;
	localparam int CFG_W   = 30;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HCAP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK = 1'd1;

	localparam logic [UTIL_W-1:0] HCAP_RST = 11'd1024;
	localparam logic [TICK_W-1:0] TICK_RST = 30'd4000000;

	// Request types
	localparam logic REQ_EVENT = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	// Capacity scale and boost floor
	localparam int CAP_SHIFT = 10;
	localparam int CAPACITY_SCALE = 1 << CAP_SHIFT;
	localparam logic [UTIL_W-1:0] CAP_MAX   = UTIL_W'(CAPACITY_SCALE);
	localparam logic [UTIL_W-1:0] BOOST_MIN = UTIL_W'(CAPACITY_SCALE / 8);

	// Headroom: delta_t = (C*220)>>10, threshold = C*15/100
	localparam int HR_MUL   = 220;
	localparam int HR_SHIFT = 10;
	localparam int DT_W     = 9;
	localparam int THR_PCT  = 15;
	localparam int PCT_DIV  = 100;
	// C*15/100 as multiply by ceil(2^22/100); exact for C*15 below 43690
	localparam int THR_SH   = 22;
	localparam int THR_RCP  = ((1 << THR_SH) + PCT_DIV - 1) / PCT_DIV;
	localparam int THR_MUL  = THR_PCT * THR_RCP;
	localparam int THR_PW   = 31;

	// Divider sizes: numerator is delta_t times an 11-bit value
	localparam int DIV_NW = DT_W + UTIL_W;
	localparam int DIV_DW = UTIL_W;

	// One entry of per-cpu boost state
	typedef struct packed {
		logic [UTIL_W-1:0] level;
		logic              pend;
		logic [TIME_W-1:0] last;
	} cur_ent_t;

	localparam int ENT_W = $bits(cur_ent_t);

	typedef struct packed {
		logic              start;
		logic              req_type;
		logic [CPU_W-1:0]  cpu;
		logic [TIME_W-1:0] time_ns;
		logic              flag;
		logic [UTIL_W-1:0] cap;
	} cur_st_req_t;

	typedef struct packed {
		logic              done;
		logic [UTIL_W-1:0] boost;
	} cur_st_rsp_t;

endpackage

### design/cur_req_if.sv
interface cur_req_if import cur_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [CPU_W-1:0]  cpu_index;
	logic [TIME_W-1:0] time_ns;
	logic              iowait_flag;
	logic [UTIL_W-1:0] util_cfs;
	logic [UTIL_W-1:0] util_rt;
	logic [UTIL_W-1:0] util_dl;
	logic [UTIL_W-1:0] cpu_capacity;

	modport source (
		output valid, req_type, cpu_index, time_ns, iowait_flag,
			util_cfs, util_rt, util_dl, cpu_capacity,
		input  ready
	);
	modport sink (
		input  valid, req_type, cpu_index, time_ns, iowait_flag,
			util_cfs, util_rt, util_dl, cpu_capacity,
		output ready
	);
endinterface

### design/cur_rsp_if.sv
interface cur_rsp_if import cur_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CPU_W-1:0]  cpu_index_out;
	logic [UTIL_W-1:0] util_request;
	logic [UTIL_W-1:0] boost_util;

	modport source (
		output valid, cpu_index_out, util_request, boost_util,
		input  ready
	);
	modport sink (
		input  valid, cpu_index_out, util_request, boost_util,
		output ready
	);
endinterface

### design/cpu_util_request_with_iowait_boost.sv
// channel  dir  handshake          beat
// req      in   req.valid/ready    req_type, cpu_index, time_ns, iowait_flag, utils, capacity
// rsp      out  rsp.valid/ready    cpu_index_out, util_request, boost_util (evaluate only)
// cfg      in   cfg_wen            cfg_idx, cfg_wdata
//
// Evaluate beat: two 20-step divisions in the shared radix-2 divider. Event beat:
// one read-modify-write of the boost memory (read, time compare, write-back, done).
// A new beat is accepted only once the previous one has finished.
// Reset clears control and the per-entry written bits and sets the config registers
// to their defaults; boost memory itself is not cleared, unwritten entries read as zero.
// A result waits in the output register while the next beat is accepted;
// a finished evaluate holds in its last state until that register is free.
module cpu_util_request_with_iowait_boost import cur_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	cur_req_if.sink              req,
	cur_rsp_if.source            rsp,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] ST_EVT   = 4'd1;
	localparam logic [ST_W-1:0] ST_PREP  = 4'd2;
	localparam logic [ST_W-1:0] ST_MULH  = 4'd3;
	localparam logic [ST_W-1:0] ST_GOH   = 4'd4;
	localparam logic [ST_W-1:0] ST_WAITH = 4'd5;
	localparam logic [ST_W-1:0] ST_GOA   = 4'd6;
	localparam logic [ST_W-1:0] ST_WAITA = 4'd7;
	localparam logic [ST_W-1:0] ST_FIN   = 4'd8;
	localparam logic [ST_W-1:0] ST_OUT   = 4'd9;

	localparam int HR_W = DIV_NW + 1;

	logic [ST_W-1:0]   state_q;
	logic              ovld_q;
	logic              bst_rdy_q;

	logic [UTIL_W-1:0] hcap_q;
	logic [TICK_W-1:0] tick_q;
	logic [UTIL_W-1:0] thr_q;
	logic [DT_W-1:0]   dt_q;
	logic [UTIL_W-1:0] hden_q;

	logic [CPU_W-1:0]  cpu_q;
	logic [UTIL_W-1:0] cap_q;
	logic [SUM_W-1:0]  sum_q;
	logic [UTIL_W-1:0] capped_q;
	logic [UTIL_W-1:0] delta_q;
	logic [DIV_NW-1:0] prod_q;
	logic [DIV_NW-1:0] h_q;
	logic [DIV_NW-1:0] a_q;
	logic [UTIL_W-1:0] bst_q;
	logic [UTIL_W-1:0] req_q;
	logic [CPU_W-1:0]  o_cpu_q;
	logic [UTIL_W-1:0] o_req_q;
	logic [UTIL_W-1:0] o_bst_q;

	logic              accept;
	logic              out_free;
	cur_st_req_t       sreq;
	cur_st_rsp_t       srsp;
	logic              div_start;
	logic [DIV_DW-1:0] div_den;
	logic              div_busy;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;

	logic [THR_PW-1:0] thr_prod;
	logic [UTIL_W+8-1:0] dt_prod;
	logic [SUM_W-1:0]  util;
	logic [UTIL_W-1:0] util_c;
	logic [UTIL_W-1:0] capped;
	logic [DIV_NW-1:0] hsel;
	logic [HR_W-1:0]   hr;
	logic [HR_W-1:0]   mx;

	assign req.ready = state_q == ST_IDLE;
	assign accept    = req.valid && req.ready;
	assign out_free  = !ovld_q || rsp.ready;

	assign sreq.start    = accept;
	assign sreq.req_type = req.req_type;
	assign sreq.cpu      = req.cpu_index;
	assign sreq.time_ns  = req.time_ns;
	assign sreq.flag     = req.iowait_flag;
	assign sreq.cap      = req.cpu_capacity;

	cur_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.sreq   (sreq),
		.tick   (tick_q),
		.srsp   (srsp)
	);

	assign div_start = state_q == ST_GOH || state_q == ST_GOA;
	assign div_den   = (state_q == ST_GOH) ? hden_q : thr_q;

	cur_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Headroom constants follow the config register
	assign thr_prod = THR_PW'(hcap_q) * THR_PW'(THR_MUL);
	assign dt_prod  = (UTIL_W+8)'(hcap_q) * (UTIL_W+8)'(HR_MUL);

	always_comb begin
		util   = sum_q;
		if (util > {2'b0, cap_q}) begin
			util = {2'b0, cap_q};
		end
		util_c = (util > {2'b0, CAP_MAX}) ? CAP_MAX : util[UTIL_W-1:0];
		capped = (util_c < hcap_q) ? util_c : hcap_q;
	end

	always_comb begin
		hsel = (thr_q != '0 && a_q < h_q) ? a_q : h_q;
		hr   = (hden_q == '0) ? HR_W'(capped_q) : HR_W'(capped_q) + HR_W'(hsel);
		mx   = (HR_W'(bst_q) > hr) ? HR_W'(bst_q) : hr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcap_q <= HCAP_RST;
			tick_q <= TICK_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_HCAP: hcap_q <= cfg_wdata[UTIL_W-1:0];
				CFG_TICK: tick_q <= cfg_wdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		thr_q  <= UTIL_W'(thr_prod >> THR_SH);
		dt_q   <= DT_W'(dt_prod >> HR_SHIFT);
		hden_q <= hcap_q - thr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ovld_q    <= 1'b0;
			bst_rdy_q <= 1'b0;
		end else begin
			if (accept) begin
				bst_rdy_q <= 1'b0;
			end else if (srsp.done) begin
				bst_rdy_q <= 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				ovld_q <= 1'b1;
			end else if (rsp.ready) begin
				ovld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:  if (accept) begin
					state_q <= (req.req_type == REQ_EVAL) ? ST_PREP : ST_EVT;
				end
				ST_EVT:   if (srsp.done) begin
					state_q <= ST_IDLE;
				end
				ST_PREP:  state_q <= ST_MULH;
				ST_MULH:  state_q <= ST_GOH;
				ST_GOH:   state_q <= ST_WAITH;
				ST_WAITH: if (div_done) begin
					state_q <= ST_GOA;
				end
				ST_GOA:   state_q <= ST_WAITA;
				ST_WAITA: if (div_done) begin
					state_q <= ST_FIN;
				end
				ST_FIN:   if (bst_rdy_q) begin
					state_q <= ST_OUT;
				end
				ST_OUT:   if (out_free) begin
					state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cpu_q <= req.cpu_index;
			cap_q <= req.cpu_capacity;
			sum_q <= SUM_W'(req.util_cfs) + SUM_W'(req.util_rt) + SUM_W'(req.util_dl);
		end
		if (srsp.done) begin
			bst_q <= srsp.boost;
		end
		if (state_q == ST_PREP) begin
			capped_q <= capped;
			delta_q  <= hcap_q - capped;
		end
		if (state_q == ST_MULH) begin
			prod_q <= dt_q * delta_q;
		end
		if (state_q == ST_WAITH && div_done) begin
			h_q    <= div_quo;
			prod_q <= dt_q * capped_q;
		end
		if (state_q == ST_WAITA && div_done) begin
			a_q <= div_quo;
		end
		if (state_q == ST_FIN) begin
			req_q <= (mx > HR_W'(cap_q)) ? cap_q : mx[UTIL_W-1:0];
		end
		if (state_q == ST_OUT && out_free) begin
			o_cpu_q <= cpu_q;
			o_req_q <= req_q;
			o_bst_q <= bst_q;
		end
	end

	assign rsp.valid         = ovld_q;
	assign rsp.cpu_index_out = o_cpu_q;
	assign rsp.util_request  = o_req_q;
	assign rsp.boost_util    = o_bst_q;

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovld_q) |-> $past(state_q == ST_OUT))
		else $error("result beat raised outside the output state");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_busy)
		else $error("beat accepted while divider busy");
endmodule

### design/cur_ram.sv
module cur_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### design/cur_div.sv
module cur_div import cur_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              busy,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);
	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] nq_q;

	logic [DIV_DW:0]   sh;
	logic [DIV_DW:0]   dif;
	logic              ge;

	// Restoring radix-2 step: quotient bits shift in where numerator bits leave
	always_comb begin
		sh  = {rem_q, nq_q[DIV_NW-1]};
		dif = sh - {1'b0, den_q};
		ge  = sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_NW);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			nq_q  <= num;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? dif[DIV_DW-1:0] : sh[DIV_DW-1:0];
			nq_q  <= {nq_q[DIV_NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = busy_q && cnt_q == '0;
	assign quo  = nq_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done && !start |=> !busy_q)
		else $error("divider still busy after done");
endmodule

### design/cur_state.sv
module cur_state import cur_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cur_st_req_t       sreq,
	input  logic [TICK_W-1:0] tick,
	output cur_st_rsp_t       srsp
);
	logic [NUM_CPUS-1:0] vld_q;
	logic                v_s1, v_s2, v_s3;

	cur_st_req_t       rq_s1, rq_s2;
	logic              rv_s1;
	cur_ent_t          ent_s2;
	logic              newer_s2;
	logic [TIME_W-1:0] diff_s2;
	logic [UTIL_W-1:0] lvl_s3;
	logic [UTIL_W-1:0] cap_s3;

	logic [ENT_W-1:0]  ram_rd;
	cur_ent_t          ent_s1;
	logic [TIME_W:0]   sub_s1;
	cur_ent_t          ent_new;
	logic              to_s2;
	logic              lvl_nz;
	logic [UTIL_W:0]   dbl;
	logic [UTIL_W-1:0] half;
	logic [2*UTIL_W-1:0] prod_s3;

	cur_ram #(.WIDTH(ENT_W), .DEPTH(NUM_CPUS)) u_ram (
		.clk   (clk),
		.we    (v_s2),
		.waddr (rq_s2.cpu),
		.wdata (ent_new),
		.re    (sreq.start),
		.raddr (sreq.cpu),
		.rdata (ram_rd)
	);

	// Entry never written reads as the reset state
	always_comb begin
		ent_s1 = rv_s1 ? cur_ent_t'(ram_rd) : '0;
		sub_s1 = {1'b0, rq_s1.time_ns} - {1'b0, ent_s1.last};
	end

	always_comb begin
		to_s2  = newer_s2 && (diff_s2[TIME_W-1:TICK_W] != '0 || diff_s2[TICK_W-1:0] > tick);
		lvl_nz = ent_s2.level != '0;
		dbl    = {ent_s2.level, 1'b0};
		half   = ent_s2.level >> 1;
		ent_new = ent_s2;
		if (rq_s2.req_type == REQ_EVENT) begin
			ent_new.last = rq_s2.time_ns;
			if (lvl_nz && to_s2) begin
				ent_new.level = rq_s2.flag ? BOOST_MIN : '0;
				ent_new.pend  = rq_s2.flag;
			end else if (rq_s2.flag && !ent_s2.pend) begin
				ent_new.pend = 1'b1;
				if (!lvl_nz) begin
					ent_new.level = BOOST_MIN;
				end else if (dbl > {1'b0, CAP_MAX}) begin
					ent_new.level = CAP_MAX;
				end else begin
					ent_new.level = dbl[UTIL_W-1:0];
				end
			end
		end else if (lvl_nz) begin
			// evaluate: zero on timeout, else decay unless an event is pending, drop below the floor
			ent_new.pend = 1'b0;
			if (to_s2) begin
				ent_new.level = '0;
			end else if (!ent_s2.pend) begin
				ent_new.level = (half < BOOST_MIN) ? '0 : half;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			vld_q <= '0;
		end else begin
			v_s1 <= sreq.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s2) begin
				vld_q[rq_s2.cpu] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sreq.start) begin
			rq_s1 <= sreq;
			rv_s1 <= vld_q[sreq.cpu];
		end
		rq_s2    <= rq_s1;
		ent_s2   <= ent_s1;
		newer_s2 <= !sub_s1[TIME_W] && sub_s1[TIME_W-1:0] != '0;
		diff_s2  <= sub_s1[TIME_W-1:0];
		lvl_s3   <= ent_new.level;
		cap_s3   <= rq_s2.cap;
	end

	assign prod_s3 = lvl_s3 * cap_s3;

	assign srsp.done  = v_s3;
	assign srsp.boost = prod_s3[CAP_SHIFT+UTIL_W-1:CAP_SHIFT];

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sreq.start |-> !(v_s1 || v_s2 || v_s3))
		else $error("state update started while another is in flight");

	a_vld_after_wr: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |=> vld_q[$past(rq_s2.cpu)])
		else $error("entry not marked written after write-back");
endmodule
